### rtl/pip_pkg.sv
package pip_pkg;

    localparam int FIELD_W = 32;
    localparam int REL_W   = FIELD_W + 1;
    localparam int TOL_W   = 31;
    localparam int T_FRAC  = 32;

    typedef enum logic [1:0] {
        REG_QUERY_U      = 2'd0,
        REG_QUERY_V      = 2'd1,
        REG_ON_TOLERANCE = 2'd2
    } pip_reg_idx_t;

    typedef enum logic [1:0] {
        CLS_OUTSIDE  = 2'd0,
        CLS_INSIDE   = 2'd1,
        CLS_BOUNDARY = 2'd2
    } pip_cls_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] start_u;
        logic signed [FIELD_W-1:0] start_v;
        logic signed [FIELD_W-1:0] end_u;
        logic signed [FIELD_W-1:0] end_v;
        logic                      last_edge;
    } pip_edge_t;

    typedef struct packed {
        logic [1:0] classification;
    } pip_result_t;

    typedef struct packed {
        logic [1:0]         index;
        logic [FIELD_W-1:0] data;
    } pip_cfg_t;

    // One edge as the back end sees it: both end points relative to the query.
    typedef struct packed {
        logic signed [REL_W-1:0] au;
        logic signed [REL_W-1:0] av;
        logic signed [REL_W-1:0] bu;
        logic signed [REL_W-1:0] bv;
        logic                    a_below;
        logic                    straddle;
        logic                    last_edge;
    } pip_work_t;

endpackage

### rtl/pip_chan_if.sv
interface pip_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pip_front.sv
module pip_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pip_chan_if.sink                       edge_in,
    pip_chan_if.sink                       cfg_in,
    input  logic                           q_full,
    output logic                           q_push,
    output pip_pkg::pip_work_t             q_wdata,
    output logic [pip_pkg::TOL_W-1:0]      tol
);
    import pip_pkg::*;

    localparam int CB = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int SH = FIELD_W - CB;

    logic [FIELD_W-1:0] query_u_reg;
    logic [FIELD_W-1:0] query_v_reg;
    logic [TOL_W-1:0]   tol_reg;

    logic signed [FIELD_W-1:0] qu, qv, su, sv, eu, ev;

    // Only the low CB bits of a coordinate count, sign-extended.
    function automatic logic signed [FIELD_W-1:0] coord(input logic [FIELD_W-1:0] raw);
        logic signed [FIELD_W-1:0] tmp;
        tmp = $signed(raw << SH);
        return tmp >>> SH;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_u_reg <= '0;
            query_v_reg <= '0;
            tol_reg     <= '0;
        end
        else if (cfg_in.valid)
        begin
            case (pip_reg_idx_t'(cfg_in.payload.index))
                REG_QUERY_U:      query_u_reg <= cfg_in.payload.data;
                REG_QUERY_V:      query_v_reg <= cfg_in.payload.data;
                REG_ON_TOLERANCE: tol_reg     <= cfg_in.payload.data[TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_in.ready  = 1'b1;
    assign edge_in.ready = !q_full;
    assign q_push        = edge_in.valid && !q_full;
    assign tol           = tol_reg;

    always_comb
    begin
        qu = coord(query_u_reg);
        qv = coord(query_v_reg);
        su = coord(edge_in.payload.start_u);
        sv = coord(edge_in.payload.start_v);
        eu = coord(edge_in.payload.end_u);
        ev = coord(edge_in.payload.end_v);
        q_wdata.au = REL_W'(su) - REL_W'(qu);
        q_wdata.av = REL_W'(sv) - REL_W'(qv);
        q_wdata.bu = REL_W'(eu) - REL_W'(qu);
        q_wdata.bv = REL_W'(ev) - REL_W'(qv);
        // Half-open rule: a point on the line counts as below.
        q_wdata.a_below   = (q_wdata.av <= 0);
        q_wdata.straddle  = (q_wdata.av <= 0) != (q_wdata.bv <= 0);
        q_wdata.last_edge = edge_in.payload.last_edge;
    end

endmodule

### rtl/pip_queue.sv
module pip_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pip_pkg::pip_work_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output pip_pkg::pip_work_t rdata
);
    import pip_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    pip_work_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/pip_back.sv
module pip_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  pip_pkg::pip_work_t        q_rdata,
    output logic                      q_pop,
    input  logic [pip_pkg::TOL_W-1:0] tol,
    pip_chan_if.source                result_out
);
    import pip_pkg::*;

    localparam int MW = 34;
    localparam int PW = 2 * MW;

    typedef enum logic [4:0] {
        S_IDLE, S_CR1, S_CR2, S_L1, S_L2, S_S1, S_S2, S_SA, S_DEC, S_DIV,
        S_F1, S_F2, S_F3, S_D1, S_D2, S_D3, S_EMIT
    } state_t;

    state_t                  state_reg;
    pip_work_t               w_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    acc_reg;
    logic [PW-1:0]           l2_reg;
    logic [PW-1:0]           r_reg;
    logic [T_FRAC:0]         t_reg;
    logic [4:0]              cnt_reg;
    logic signed [MW-1:0]    eu_reg;
    logic                    parity_reg;
    logic                    hit_reg;
    logic                    res_valid_reg;
    logic [1:0]              res_cls_reg;

    logic signed [REL_W-1:0] du, dv, wu, wv;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    prod;
    logic [PW-1:0]           r_shift;
    logic signed [MW-1:0]    e_next;
    logic                    emit_fire;

    function automatic logic signed [MW-1:0] sx(input logic signed [REL_W-1:0] x);
        return MW'(x);
    endfunction

    // round(p / 2^32), half away from zero
    function automatic logic signed [MW-1:0] foot(input logic signed [PW-1:0] p);
        logic [PW-1:0] pm;
        logic [PW-1:0] pr;
        pm = p[PW-1] ? PW'(-p) : PW'(p);
        pr = pm + (PW'(1) << (T_FRAC - 1));
        return p[PW-1] ? -$signed(pr[T_FRAC +: MW]) : $signed(pr[T_FRAC +: MW]);
    endfunction

    always_comb
    begin
        du = w_reg.bu - w_reg.au;
        dv = w_reg.bv - w_reg.av;
        wu = -w_reg.au;
        wv = -w_reg.av;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CR1: begin mul_a = sx(w_reg.au); mul_b = sx(w_reg.bv); end
            S_CR2: begin mul_a = sx(w_reg.av); mul_b = sx(w_reg.bu); end
            S_L1:  begin mul_a = sx(du); mul_b = sx(du); end
            S_L2:  begin mul_a = sx(dv); mul_b = sx(dv); end
            S_S1:  begin mul_a = sx(wu); mul_b = sx(du); end
            S_S2:  begin mul_a = sx(wv); mul_b = sx(dv); end
            S_F1:  begin mul_a = $signed(MW'(t_reg)); mul_b = sx(du); end
            S_F2:  begin mul_a = $signed(MW'(t_reg)); mul_b = sx(dv); end
            S_F3:  begin mul_a = eu_reg; mul_b = eu_reg; end
            S_D1:  begin mul_a = eu_reg; mul_b = eu_reg; end
            S_D2:  begin mul_a = $signed(MW'(tol)); mul_b = $signed(MW'(tol)); end
            default: ;
        endcase
        prod    = mul_a * mul_b;
        r_shift = r_reg << 1;
        // In F2 this is the u error; in F3 it is the v error.
        e_next  = (state_reg == S_F2) ? sx(wu) - foot(prod_reg) : sx(wv) - foot(prod_reg);
    end

    assign q_pop            = (state_reg == S_IDLE) && !q_empty;
    assign emit_fire        = (state_reg == S_EMIT) && (!res_valid_reg || result_out.ready);
    assign result_out.valid = res_valid_reg;
    assign result_out.payload.classification = res_cls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            parity_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= prod;
            if (res_valid_reg && result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        w_reg     <= q_rdata;
                        state_reg <= S_CR1;
                    end
                end
                S_CR1: state_reg <= S_CR2;
                S_CR2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_L1;
                end
                S_L1:
                begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= S_L2;
                end
                S_L2:
                begin
                    if (w_reg.straddle &&
                        ((w_reg.a_below && acc_reg > 0) || (!w_reg.a_below && acc_reg < 0)))
                    begin
                        parity_reg <= !parity_reg;
                    end
                    l2_reg    <= prod_reg;
                    state_reg <= S_S1;
                end
                S_S1:
                begin
                    l2_reg    <= l2_reg + prod_reg;
                    state_reg <= S_S2;
                end
                S_S2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SA;
                end
                S_SA:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    t_reg   <= '0;
                    r_reg   <= acc_reg;
                    cnt_reg <= '0;
                    if (l2_reg == '0 || acc_reg <= 0)
                    begin
                        state_reg <= S_F1;
                    end
                    else if (acc_reg >= $signed(l2_reg))
                    begin
                        t_reg     <= (T_FRAC+1)'(1) << T_FRAC;
                        state_reg <= S_F1;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (r_shift >= l2_reg)
                    begin
                        r_reg <= r_shift - l2_reg;
                        t_reg <= {t_reg[T_FRAC-1:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_shift;
                        t_reg <= {t_reg[T_FRAC-1:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(T_FRAC - 1))
                    begin
                        state_reg <= S_F1;
                    end
                end
                S_F1: state_reg <= S_F2;
                S_F2:
                begin
                    eu_reg    <= e_next;
                    state_reg <= S_F3;
                end
                S_F3:
                begin
                    // The u error is squared now; the v error takes its place.
                    eu_reg    <= e_next;
                    state_reg <= S_D1;
                end
                S_D1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= S_D3;
                end
                S_D3:
                begin
                    if ($unsigned(prod_reg) >= $unsigned(acc_reg))
                    begin
                        hit_reg <= 1'b1;
                    end
                    state_reg <= w_reg.last_edge ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        res_valid_reg <= 1'b1;
                        res_cls_reg   <= hit_reg ? CLS_BOUNDARY :
                                         (parity_reg ? CLS_INSIDE : CLS_OUTSIDE);
                        parity_reg    <= 1'b0;
                        hit_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> r_reg < l2_reg)
        else $error("division remainder not below divisor");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_F1 |-> t_reg <= ((T_FRAC+1)'(1) << T_FRAC))
        else $error("foot parameter above one");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> !parity_reg && !hit_reg && res_valid_reg)
        else $error("state not cleared after result");

    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

endmodule

### rtl/point_in_polygon_classifier.sv
// Point-in-polygon classifier with a boundary band.
// The query point and the tolerance are set through cfg_in (index 0 query u,
// 1 query v, 2 tolerance); write them only while the block is idle.
// Each beat on edge_in carries one closed polygon edge; outer and hole rings
// may be mixed in any order. The beat with last_edge set closes the set and
// yields one beat on result_out: outside, inside, or on the boundary band.
// Other edges yield no result beat.
// Each edge runs through the shared multiplier sequence; when the foot
// parameter is not clamped, the 32-step radix-2 divider runs as well.
// A last edge also passes through the emit state to load the result
// register. A two-beat queue sits between the front and the sequencer,
// so edges are accepted while work goes on.
// When result_out stalls, the result waits in its register; the sequencer
// holds on the next last edge and the queue then fills and stops edge_in.
// Reset clears the state, the configuration registers, the queue pointers, the parity and the boundary flag.
module point_in_polygon_classifier #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pip_chan_if.sink   edge_in,
    pip_chan_if.sink   cfg_in,
    pip_chan_if.source result_out
);
    import pip_pkg::*;

    // Queue handshake between front and back.
    logic            q_full;
    logic            q_push;
    logic            q_empty;
    logic            q_pop;
    pip_work_t       q_wdata;
    pip_work_t       q_rdata;
    logic [TOL_W-1:0] tol;

    // The front converts coordinates relative to the query point and
    // decides the half-open straddle at once.
    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_in),
        .cfg_in  (cfg_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .tol     (tol)
    );

    pip_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // The back end runs the crossing product, the clamped foot division and
    // the squared distance through one multiplier, then keeps the result.
    pip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .tol        (tol),
        .result_out (result_out)
    );

endmodule
